[rtl/core/csa_pkg.sv]
package csa_pkg;

    localparam int OP_W   = 2;
    localparam int WID_W  = 7;
    localparam int DATA_W = 64;
    localparam int HALF_W = DATA_W / 2;

    // operation codes
    localparam logic [OP_W-1:0] OP_ADD = 2'd0;
    localparam logic [OP_W-1:0] OP_SUB = 2'd1;
    localparam logic [OP_W-1:0] OP_MUL = 2'd2;

    localparam logic [WID_W-1:0] WID_MIN = 7'd1;
    localparam logic [WID_W-1:0] WID_MAX = 7'd64;

    // stream payload layout
    localparam int S_TDATA_W = 144;
    localparam int M_TDATA_W = 64;
    localparam int M_TUSER_W = 1;

endpackage

[rtl/core/checked_signed_arith.sv]
// Overflow-checked signed add, subtract and multiply on 64-bit operands. Each
// beat carries an operation, a target width of 1..64 bits and two operands; the
// exact result (65-bit sum or difference, full 128-bit product) is checked
// against the signed range of that width and returned with ok set, or zero with
// ok clear on overflow or an unused operation code. Width 0 acts as 1, widths
// above 64 act as 64. One beat is accepted every cycle while the output is not
// stalled. Each beat passes through these registered steps: four 32x32 partial
// products, their 128-bit accumulation, the signed correction, then the range
// check and output register. Stalls on the output back up stage by stage.
module checked_signed_arith (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [143:0] s_tdata,   // op[1:0], width_bits[8:2], lhs[72:9], rhs[136:73]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // value[63:0]
    output logic [0:0]   m_tuser    // ok[0]
);

    localparam int OP_W   = csa_pkg::OP_W;
    localparam int WID_W  = csa_pkg::WID_W;
    localparam int DATA_W = csa_pkg::DATA_W;
    localparam int HALF_W = csa_pkg::HALF_W;

    // input unpack
    logic [OP_W-1:0]   in_op;
    logic [WID_W-1:0]  in_wid;
    logic [DATA_W-1:0] in_a;
    logic [DATA_W-1:0] in_b;
    logic [WID_W-1:0]  in_wid_clamp;

    assign in_op  = s_tdata[1:0];
    assign in_wid = s_tdata[8:2];
    assign in_a   = s_tdata[72:9];
    assign in_b   = s_tdata[136:73];

    always_comb
    begin
        if (in_wid < csa_pkg::WID_MIN)
            in_wid_clamp = csa_pkg::WID_MIN;
        else if (in_wid > csa_pkg::WID_MAX)
            in_wid_clamp = csa_pkg::WID_MAX;
        else
            in_wid_clamp = in_wid;
    end

    // handshake chain
    logic v1_reg, v2_reg, v3_reg, vo_reg;
    logic en1, en2, en3, en_out;

    assign en_out   = !vo_reg || m_tready;
    assign en3      = !v3_reg || en_out;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;

    // stage 1: partial products, add/sub, sign correction term
    logic [HALF_W-1:0] a_lo, a_hi, b_lo, b_hi;
    logic [DATA_W-1:0] pp_ll_next, pp_lh_next, pp_hl_next, pp_hh_next;
    logic [DATA_W:0]   sum_next;
    logic [DATA_W-1:0] corr_next;

    assign a_lo = in_a[HALF_W-1:0];
    assign a_hi = in_a[DATA_W-1:HALF_W];
    assign b_lo = in_b[HALF_W-1:0];
    assign b_hi = in_b[DATA_W-1:HALF_W];

    always_comb
    begin
        pp_ll_next = {{HALF_W{1'b0}}, a_lo} * {{HALF_W{1'b0}}, b_lo};
        pp_lh_next = {{HALF_W{1'b0}}, a_lo} * {{HALF_W{1'b0}}, b_hi};
        pp_hl_next = {{HALF_W{1'b0}}, a_hi} * {{HALF_W{1'b0}}, b_lo};
        pp_hh_next = {{HALF_W{1'b0}}, a_hi} * {{HALF_W{1'b0}}, b_hi};
        if (in_op == csa_pkg::OP_SUB)
            sum_next = {in_a[DATA_W-1], in_a} - {in_b[DATA_W-1], in_b};
        else
            sum_next = {in_a[DATA_W-1], in_a} + {in_b[DATA_W-1], in_b};
        // unsigned product to signed: hi -= b if a<0, hi -= a if b<0
        corr_next = (in_a[DATA_W-1] ? in_b : '0) + (in_b[DATA_W-1] ? in_a : '0);
    end

    logic [OP_W-1:0]   op1_reg;
    logic [WID_W-1:0]  wid1_reg;
    logic [DATA_W-1:0] pp_ll_reg, pp_lh_reg, pp_hl_reg, pp_hh_reg;
    logic [DATA_W:0]   sum1_reg;
    logic [DATA_W-1:0] corr1_reg;

    // stage 2: accumulate unsigned 128-bit product
    logic [2*DATA_W-1:0] uprod_next;

    assign uprod_next = {pp_hh_reg, pp_ll_reg}
                      + {{HALF_W{1'b0}}, pp_lh_reg, {HALF_W{1'b0}}}
                      + {{HALF_W{1'b0}}, pp_hl_reg, {HALF_W{1'b0}}};

    logic [OP_W-1:0]     op2_reg;
    logic [WID_W-1:0]    wid2_reg;
    logic [2*DATA_W-1:0] uprod_reg;
    logic [DATA_W:0]     sum2_reg;
    logic [DATA_W-1:0]   corr2_reg;

    // stage 3: signed fix-up and result select
    logic [DATA_W-1:0] res_hi_next, res_lo_next;
    logic              bad_op_next;

    always_comb
    begin
        res_hi_next = {DATA_W{sum2_reg[DATA_W]}};
        res_lo_next = sum2_reg[DATA_W-1:0];
        bad_op_next = 1'b0;
        case (op2_reg)
            csa_pkg::OP_ADD,
            csa_pkg::OP_SUB:
            begin
                res_hi_next = {DATA_W{sum2_reg[DATA_W]}};
                res_lo_next = sum2_reg[DATA_W-1:0];
            end
            csa_pkg::OP_MUL:
            begin
                res_hi_next = uprod_reg[2*DATA_W-1:DATA_W] - corr2_reg;
                res_lo_next = uprod_reg[DATA_W-1:0];
            end
            default:
            begin
                bad_op_next = 1'b1;
            end
        endcase
    end

    logic [WID_W-1:0]  wid3_reg;
    logic [DATA_W-1:0] res_hi_reg, res_lo_reg;
    logic              bad_op_reg;

    // stage 4: range check
    logic [DATA_W-1:0] upper_mask;
    logic [DATA_W-1:0] lo_flip;
    logic              fits;

    always_comb
    begin
        // bits at and above w-1 must all match the sign
        for (int i = 0; i < DATA_W; i++)
            upper_mask[i] = ({1'b0, WID_W'(i)} + 8'd1) >= {1'b0, wid3_reg};
        lo_flip = res_lo_reg ^ {DATA_W{res_lo_reg[DATA_W-1]}};
        fits    = !bad_op_reg
               && (res_hi_reg == {DATA_W{res_lo_reg[DATA_W-1]}})
               && ((lo_flip & upper_mask) == '0);
    end

    logic [DATA_W-1:0] value_reg;
    logic              ok_reg;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= s_tvalid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
            if (en_out)
                vo_reg <= v3_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            op1_reg   <= in_op;
            wid1_reg  <= in_wid_clamp;
            pp_ll_reg <= pp_ll_next;
            pp_lh_reg <= pp_lh_next;
            pp_hl_reg <= pp_hl_next;
            pp_hh_reg <= pp_hh_next;
            sum1_reg  <= sum_next;
            corr1_reg <= corr_next;
        end
        if (en2)
        begin
            op2_reg   <= op1_reg;
            wid2_reg  <= wid1_reg;
            uprod_reg <= uprod_next;
            sum2_reg  <= sum1_reg;
            corr2_reg <= corr1_reg;
        end
        if (en3)
        begin
            wid3_reg   <= wid2_reg;
            res_hi_reg <= res_hi_next;
            res_lo_reg <= res_lo_next;
            bad_op_reg <= bad_op_next;
        end
        if (en_out)
        begin
            value_reg <= fits ? res_lo_reg : '0;
            ok_reg    <= fits;
        end
    end

    assign m_tvalid   = vo_reg;
    assign m_tdata    = value_reg;
    assign m_tuser[0] = ok_reg;

`ifndef NO_ASSERTIONS
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("overflow result not zero");

    a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        !v1_reg |-> s_tready)
        else $error("input stalled with empty first stage");

    a_s1_advance: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && en2 |=> v2_reg)
        else $error("beat lost between stage 1 and 2");

    a_s3_advance: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && en_out |=> m_tvalid)
        else $error("beat lost before output");
`endif

endmodule

[tb/tb_checked_signed_arith.sv]
module tb_checked_signed_arith;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int OP_W      = csa_pkg::OP_W;
    localparam int WID_W     = csa_pkg::WID_W;
    localparam int DATA_W    = csa_pkg::DATA_W;
    localparam int S_TDATA_W = csa_pkg::S_TDATA_W;
    localparam int M_TDATA_W = csa_pkg::M_TDATA_W;
    localparam int M_TUSER_W = csa_pkg::M_TUSER_W;

    localparam logic [OP_W-1:0]   OP_UNUSED = 2'd3;
    localparam logic signed [63:0] S64_MAX  = 64'sh7fff_ffff_ffff_ffff;
    localparam logic signed [63:0] S64_MIN  = 64'sh8000_0000_0000_0000;
    localparam int                 LONG_HOLD = 200;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              ok;
    } arith_res_t;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    arith_res_t pending_results[$];
    int         mismatch_cnt = 0;
    bit         tx_idle_en   = 1'b1;
    bit         rx_idle_en   = 1'b1;
    int         rx_hold      = 0;

    checked_signed_arith u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // exact result at 128 bits, then a range check against the effective width
    function automatic arith_res_t predict_arith(input logic [OP_W-1:0] op,
                                                 input logic [WID_W-1:0] wid,
                                                 input logic signed [63:0] lhs,
                                                 input logic signed [63:0] rhs);
        logic signed [127:0] ea;
        logic signed [127:0] eb;
        logic signed [127:0] exact;
        logic signed [127:0] lim;
        int unsigned         w;
        bit                  legal;
        arith_res_t          r;
        w     = (wid == 0) ? 1 : ((wid > csa_pkg::WID_MAX) ? 64 : int'(wid));
        ea    = lhs;
        eb    = rhs;
        legal = 1'b1;
        exact = '0;
        case (op)
            csa_pkg::OP_ADD: exact = ea + eb;
            csa_pkg::OP_SUB: exact = ea - eb;
            csa_pkg::OP_MUL: exact = ea * eb;
            default:         legal = 1'b0;
        endcase
        lim   = 128'sd1 <<< (w - 1);
        r.ok    = legal && (exact >= -lim) && (exact < lim);
        r.value = r.ok ? exact[63:0] : '0;
        return r;
    endfunction

    // operand shapes that land near the range limits of width w as well as anywhere
    function automatic logic [63:0] pick_operand(input int unsigned w);
        logic [63:0]        raw;
        logic signed [63:0] s;
        int unsigned        k;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 4))
            0: s = raw;
            1:
            begin
                k = $urandom_range(1, 64);
                s = raw << (64 - k);
                s = s >>> (64 - k);
            end
            2:
            begin
                s = 64'sd1 <<< (w - 1);
                s = s + (int'($urandom_range(0, 4)) - 2);
                if ($urandom_range(0, 1))
                    s = -s;
            end
            3:
            begin
                case ($urandom_range(0, 4))
                    0: s = 0;
                    1: s = 1;
                    2: s = -1;
                    3: s = S64_MIN;
                    default: s = S64_MAX;
                endcase
            end
            default:
            begin
                k = (w + 1) / 2;
                s = raw << (64 - k);
                s = s >>> (64 - k);
            end
        endcase
        return s;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        mismatch_cnt++;
    endtask

    task automatic send_beat(input logic [OP_W-1:0] op, input logic [WID_W-1:0] wid,
                             input logic [63:0] lhs, input logic [63:0] rhs);
        int gap;
        gap = (tx_idle_en && $urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, rhs, lhs, wid, op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_results = {pending_results, predict_arith(op, wid, lhs, rhs)};
    endtask

    task automatic send_random_beat();
        logic [OP_W-1:0]  op;
        logic [WID_W-1:0] wid;
        int unsigned      w;
        op = ($urandom_range(0, 15) == 0) ? OP_UNUSED : OP_W'($urandom_range(0, 2));
        if ($urandom_range(0, 6) == 0)
            wid = ($urandom_range(0, 2) == 0) ? 7'd0 : WID_W'($urandom_range(65, 127));
        else
            wid = WID_W'($urandom_range(1, 64));
        w = (wid == 0) ? 1 : ((wid > csa_pkg::WID_MAX) ? 64 : int'(wid));
        send_beat(op, wid, pick_operand(w), pick_operand(w));
    endtask

    task automatic test_extremes();
        send_beat(csa_pkg::OP_ADD, csa_pkg::WID_MAX, S64_MAX, 64'sd1);
        send_beat(csa_pkg::OP_ADD, csa_pkg::WID_MAX, S64_MIN, -64'sd1);
        send_beat(csa_pkg::OP_ADD, csa_pkg::WID_MAX, S64_MAX, S64_MIN);
        send_beat(csa_pkg::OP_ADD, 7'd0, -64'sd1, 64'sd0);
        send_beat(csa_pkg::OP_ADD, 7'd8, 64'sd63, 64'sd64);
        send_beat(csa_pkg::OP_ADD, 7'd8, 64'sd64, 64'sd64);
        send_beat(csa_pkg::OP_SUB, csa_pkg::WID_MAX, S64_MIN, 64'sd1);
        send_beat(csa_pkg::OP_SUB, csa_pkg::WID_MAX, 64'sd0, S64_MIN);
        send_beat(csa_pkg::OP_SUB, csa_pkg::WID_MIN, S64_MAX, S64_MAX);
        send_beat(csa_pkg::OP_SUB, 7'd8, -64'sd64, 64'sd64);
        send_beat(csa_pkg::OP_SUB, 7'd8, -64'sd64, 64'sd65);
        send_beat(csa_pkg::OP_MUL, csa_pkg::WID_MAX, S64_MIN, -64'sd1);
        send_beat(csa_pkg::OP_MUL, csa_pkg::WID_MAX, S64_MIN, 64'sd1);
        send_beat(csa_pkg::OP_MUL, csa_pkg::WID_MAX, S64_MAX, S64_MAX);
        send_beat(csa_pkg::OP_MUL, 7'd127, S64_MIN, S64_MIN);
        send_beat(csa_pkg::OP_MUL, 7'd0, -64'sd1, -64'sd1);
        send_beat(csa_pkg::OP_MUL, 7'd63, 64'sd1 <<< 31, 64'sd1 <<< 31);
        send_beat(csa_pkg::OP_MUL, 7'd62, 64'sd1 <<< 31, 64'sd1 <<< 31);
        send_beat(csa_pkg::OP_MUL, csa_pkg::WID_MAX, -(64'sd1 <<< 32), 64'sd1 <<< 31);
        send_beat(csa_pkg::OP_MUL, 7'd65, -64'sd1, S64_MIN);
        send_beat(OP_UNUSED, csa_pkg::WID_MAX, 64'sd0, 64'sd0);
        send_beat(OP_UNUSED, 7'd127, -64'sd1, -64'sd1);
    endtask

    task automatic test_random_ops(input int n);
        repeat (n) send_random_beat();
    endtask

    // sink stops for a long stretch while beats keep coming; the input must stall
    task automatic test_output_stall();
        tx_idle_en = 1'b0;
        rx_hold = LONG_HOLD;
        repeat (60) send_random_beat();
        tx_idle_en = 1'b1;
    endtask

    task automatic test_full_rate(input int n);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        repeat (n) send_random_beat();
    endtask

    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            rx_hold--;
            m_tready <= 1'b0;
        end
        else if (rx_idle_en && $urandom_range(0, 5) == 0)
        begin
            rx_hold = $urandom_range(1, 3) - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin : result_check
        arith_res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected beat", m_tdata, '0);
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata !== want.value)
                    report_mismatch("value", m_tdata, want.value);
                if (m_tuser[0] !== want.ok)
                    report_mismatch("ok", 64'(m_tuser[0]), 64'(want.ok));
            end
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_extremes();
        test_random_ops(1000);
        test_output_stall();
        test_full_rate(370);
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("[checked_signed_arith] OK");
        else
            $display("[checked_signed_arith] ERROR");
        $finish;
    end

    initial
    begin
        #1_000_000;
        $display("[checked_signed_arith] ERROR");
        $finish;
    end

endmodule
